// ----- rtl/core/bcps_pkg.sv -----
// Shared types, constants and codes for the box collision pair scanner.
package bcps_pkg;

    localparam int MAX_COLLIDERS = 8;
    localparam int IDX_W         = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
    localparam int SLOT_W        = 3;
    localparam int NUM_CLASSES   = 5;
    localparam int CLASS_W       = 3;
    localparam int MASK_W        = NUM_CLASSES * NUM_CLASSES;
    localparam int MASK_IDX_W    = $clog2(MASK_W);
    localparam int COORD_W       = 16;
    localparam int SIZE_W        = 15;

    localparam logic [MASK_W-1:0] PAIR_MASK_RESET = MASK_W'(3321534);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_FULL       = 3'd1,
        ST_REMOVED    = 3'd2,
        ST_EMPTY_SLOT = 3'd3,
        ST_EVENT      = 3'd4,
        ST_SCAN_DONE  = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]                mode;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         box_width;
        logic [SIZE_W-1:0]         box_height;
        logic [CLASS_W-1:0]        box_class;
        logic                      has_receiver;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] second_slot;
        logic              last;
    } out_item_t;

    // one stored box
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [CLASS_W-1:0]        box_class;
        logic                      reports;
    } box_t;

    // verdict of the pair test: forward is a reporting to b, reverse is b reporting to a
    typedef struct packed {
        logic hit_fwd;
        logic hit_rev;
    } pair_res_t;

endpackage

// ----- rtl/core/box_collision_pair_scanner_top.sv -----
// Box collision pair scanner: slot table, pair sequencer and result output.
// Add and remove: result registered on the next edge after the item is accepted.
// Scan: table read, then one pair test per cycle over N*(N-1)/2 pairs (28 for eight
// slots), then final flush; a pair that reports both ways, or an m_ready stall, holds
// back the pair tests. Rate is set by the shared pair test unit.
// Reset (aresetn, synchronous, low): table empty, pair_mask to its default, no item held.
module box_collision_pair_scanner_top
    import bcps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_item,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [MASK_W-1:0]        pair_mask_reg;
    logic [MAX_COLLIDERS-1:0] used_reg, used_next;

    // fetch stage
    logic                     a_active_reg, a_active_next;
    logic [IDX_W-1:0]         pi_reg, pi_next;
    logic [IDX_W-1:0]         pj_reg, pj_next;
    // test stage
    logic                     b_valid_reg, b_valid_next;
    logic [IDX_W-1:0]         bi_reg, bi_next;
    logic [IDX_W-1:0]         bj_reg, bj_next;
    logic                     phase_reg, phase_next;
    // newest event, held until the next one shows whether it is last
    logic                     hold_valid_reg, hold_valid_next;
    out_item_t                hold_reg, hold_next;
    // output register
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_item_reg, m_item_next;

    box_t                     box_a, box_b, wr_box;
    pair_res_t                pres;
    logic                     mem_wr_en;
    logic [IDX_W-1:0]         free_idx;
    logic                     free_found;
    logic                     out_free;
    logic                     advance;
    logic                     ev0, ev1, cur_need, push, b_finish, b_free;
    out_item_t                push_item;
    logic [SLOT_W:0]          rm_slot_ext;
    logic                     rm_in_range;
    logic [IDX_W-1:0]         rm_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;

    // lowest free slot
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int k = MAX_COLLIDERS - 1; k >= 0; k--) begin
            if (!used_reg[k]) begin
                free_idx   = IDX_W'(k);
                free_found = 1'b1;
            end
        end
    end

    assign rm_slot_ext = {1'b0, s_item.slot};
    assign rm_in_range = rm_slot_ext < (SLOT_W + 1)'(MAX_COLLIDERS);
    assign rm_idx      = s_item.slot[IDX_W-1:0];

    assign wr_box.left      = s_item.left;
    assign wr_box.top       = s_item.top;
    assign wr_box.width     = s_item.box_width;
    assign wr_box.height    = s_item.box_height;
    assign wr_box.box_class = s_item.box_class;
    assign wr_box.reports   = s_item.has_receiver;

    assign mem_wr_en = s_valid && s_ready && (s_item.mode == MODE_ADD) && free_found;

    bcps_box_mem u_mem (
        .aclk      (aclk),
        .wr_en     (mem_wr_en),
        .wr_addr   (free_idx),
        .wr_data   (wr_box),
        .rd_en     (advance),
        .rd_addr_a (pi_reg),
        .rd_addr_b (pj_reg),
        .rd_data_a (box_a),
        .rd_data_b (box_b)
    );

    bcps_pair_unit u_pair (
        .box_a     (box_a),
        .box_b     (box_b),
        .pair_mask (pair_mask_reg),
        .res       (pres)
    );

    // test stage: up to two events per pair, one pushed per cycle unless the output stalls
    assign ev0      = b_valid_reg && used_reg[bi_reg] && used_reg[bj_reg] && pres.hit_fwd;
    assign ev1      = b_valid_reg && used_reg[bi_reg] && used_reg[bj_reg] && pres.hit_rev;
    assign cur_need = phase_reg ? 1'b1 : (ev0 || ev1);
    assign push     = b_valid_reg && cur_need && (!hold_valid_reg || out_free);
    assign b_finish = b_valid_reg && (!cur_need || push) && !(!phase_reg && ev0 && ev1);
    assign b_free   = !b_valid_reg || b_finish;
    assign advance  = a_active_reg && b_free;

    always_comb begin
        push_item.status = ST_EVENT;
        push_item.last   = 1'b0;
        if (!phase_reg && ev0) begin
            push_item.first_slot  = SLOT_W'(bi_reg);
            push_item.second_slot = SLOT_W'(bj_reg);
        end else begin
            push_item.first_slot  = SLOT_W'(bj_reg);
            push_item.second_slot = SLOT_W'(bi_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        a_active_next   = a_active_reg;
        pi_next         = pi_reg;
        pj_next         = pj_reg;
        b_valid_next    = b_valid_reg;
        bi_next         = bi_reg;
        bj_next         = bj_reg;
        phase_next      = phase_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    m_item_next.second_slot = '0;
                    m_item_next.last        = 1'b1;
                    case (s_item.mode)
                        MODE_ADD: begin
                            m_valid_next = 1'b1;
                            if (free_found) begin
                                used_next[free_idx]    = 1'b1;
                                m_item_next.status     = ST_ADDED;
                                m_item_next.first_slot = SLOT_W'(free_idx);
                            end else begin
                                m_item_next.status     = ST_FULL;
                                m_item_next.first_slot = '0;
                            end
                        end
                        MODE_REMOVE: begin
                            m_valid_next           = 1'b1;
                            m_item_next.first_slot = s_item.slot;
                            if (rm_in_range && used_reg[rm_idx]) begin
                                used_next[rm_idx]  = 1'b0;
                                m_item_next.status = ST_REMOVED;
                            end else begin
                                m_item_next.status = ST_EMPTY_SLOT;
                            end
                        end
                        MODE_SCAN: begin
                            state_next    = S_SCAN;
                            a_active_next = 1'b1;
                            pi_next       = '0;
                            pj_next       = IDX_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (advance) begin
                    bi_next = pi_reg;
                    bj_next = pj_reg;
                    if (pj_reg == IDX_W'(MAX_COLLIDERS - 1)) begin
                        if (pi_reg == IDX_W'(MAX_COLLIDERS - 2)) begin
                            a_active_next = 1'b0;
                        end else begin
                            pi_next = pi_reg + IDX_W'(1);
                            pj_next = pi_reg + IDX_W'(2);
                        end
                    end else begin
                        pj_next = pj_reg + IDX_W'(1);
                    end
                end
                b_valid_next = advance || (b_valid_reg && !b_finish);

                if (push) begin
                    if (hold_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_item_next  = hold_reg;
                    end
                    hold_valid_next = 1'b1;
                    hold_next       = push_item;
                    phase_next      = !phase_reg && ev0 && ev1;
                end

                // pipeline drained: release the held event as last, or report no events
                if (!a_active_reg && !b_valid_reg && out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (hold_valid_reg) begin
                        m_item_next      = hold_reg;
                        m_item_next.last = 1'b1;
                        hold_valid_next  = 1'b0;
                    end else begin
                        m_item_next.status      = ST_SCAN_DONE;
                        m_item_next.first_slot  = '0;
                        m_item_next.second_slot = '0;
                        m_item_next.last        = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pair_mask_reg  <= PAIR_MASK_RESET;
            used_reg       <= '0;
            a_active_reg   <= 1'b0;
            b_valid_reg    <= 1'b0;
            phase_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            a_active_reg   <= a_active_next;
            b_valid_reg    <= b_valid_next;
            phase_reg      <= phase_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                pair_mask_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pi_reg     <= pi_next;
        pj_reg     <= pj_next;
        bi_reg     <= bi_next;
        bj_reg     <= bj_next;
        hold_reg   <= hold_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // scan pipeline and held event exist only while scanning
    a_scan_pipe_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!a_active_reg && !b_valid_reg && !hold_valid_reg))
        else $error("scan pipeline busy outside scan");

    // second half of a two-way pair only follows a pushed first half
    a_phase_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(phase_reg) |-> $past(push) && b_valid_reg)
        else $error("phase set without a push");

    // an event never names the same slot twice
    a_event_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == ST_EVENT) |-> (m_item.first_slot != m_item.second_slot))
        else $error("event with equal slots");

    // the fetch counter always points at an ordered pair
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        a_active_reg |-> (pi_reg < pj_reg))
        else $error("pair counter out of order");

endmodule

// ----- rtl/core/bcps_box_mem.sv -----
// Box table memory: one write port, two registered read ports with enable.
module bcps_box_mem
    import bcps_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  box_t             wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr_a,
    input  logic [IDX_W-1:0] rd_addr_b,
    output box_t             rd_data_a,
    output box_t             rd_data_b
);

    box_t mem [MAX_COLLIDERS];
    box_t rd_a_reg;
    box_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- rtl/core/bcps_pair_unit.sv -----
// Shared pair test: strict box overlap plus class-pair mask lookup in both directions.
module bcps_pair_unit
    import bcps_pkg::*;
(
    input  box_t              box_a,
    input  box_t              box_b,
    input  logic [MASK_W-1:0] pair_mask,
    output pair_res_t         res
);

    localparam int EXT_W = COORD_W + 2;

    logic signed [EXT_W-1:0] a_l, a_t, a_r, a_b;
    logic signed [EXT_W-1:0] b_l, b_t, b_r, b_b;
    logic                    overlap;
    logic                    rep_ab;
    logic                    rep_ba;
    logic [MASK_IDX_W-1:0]   idx_ab;
    logic [MASK_IDX_W-1:0]   idx_ba;

    always_comb begin
        a_l = EXT_W'(box_a.left);
        a_t = EXT_W'(box_a.top);
        b_l = EXT_W'(box_b.left);
        b_t = EXT_W'(box_b.top);
        a_r = a_l + $signed({3'b000, box_a.width});
        a_b = a_t + $signed({3'b000, box_a.height});
        b_r = b_l + $signed({3'b000, box_b.width});
        b_b = b_t + $signed({3'b000, box_b.height});
        overlap = (a_l < b_r) && (a_r > b_l) && (a_t < b_b) && (a_b > b_t);
    end

    // bit index receiver*5 + other
    assign idx_ab = MASK_IDX_W'({box_a.box_class, 2'b00}) + MASK_IDX_W'(box_a.box_class)
                  + MASK_IDX_W'(box_b.box_class);
    assign idx_ba = MASK_IDX_W'({box_b.box_class, 2'b00}) + MASK_IDX_W'(box_b.box_class)
                  + MASK_IDX_W'(box_a.box_class);

    always_comb begin
        rep_ab = 1'b0;
        rep_ba = 1'b0;
        if (box_a.box_class < CLASS_W'(NUM_CLASSES) &&
            box_b.box_class < CLASS_W'(NUM_CLASSES)) begin
            rep_ab = box_a.reports && pair_mask[idx_ab];
            rep_ba = box_b.reports && pair_mask[idx_ba];
        end
    end

    assign res.hit_fwd = overlap && rep_ab;
    assign res.hit_rev = overlap && rep_ba;

endmodule
